### rtl/core/lcc_pkg.sv
// Shared types and constants for the LRU column cache directory.
// Used by lcc_cell and lru_column_cache_unit; no dependencies.
package lcc_pkg;

    localparam int COL_W     = 10;   // column index width
    localparam int SLOT_W    = 10;   // buffer slot width
    localparam int CNT_W     = 11;   // slot use count, holds up to 1024
    localparam int CFG_W     = 11;   // configuration data width
    localparam int CFG_IDX_W = 2;    // configuration register index width
    localparam int COL_SPAN  = 1024; // columns addressable by the index field

    localparam logic [CFG_W-1:0] MIN_CAPACITY = CFG_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(1);

    // Operation carried by an update wave along the cell row.
    typedef enum logic [1:0] {
        WM_FIND_COL,   // hit: find the column, then close the gap
        WM_FIND_FREE,  // fresh slot: append at the first empty cell
        WM_SHIFT       // close the gap from here and append at the tail
    } t_wave_mode;

    // One position of the LRU order, cell 0 is least recently used.
    typedef struct packed {
        logic              valid;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    // Update wave handed from a cell to its more-recent neighbor.
    typedef struct packed {
        logic              valid;
        t_wave_mode        mode;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
    } t_wave;

endpackage

### rtl/core/lcc_cell.sv
// One cell of the LRU order row: holds one resident column and its slot.
// Takes an update wave from its older neighbor and hands it on; uses lcc_pkg.
module lcc_cell
    import lcc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_wave  i_wave,
    input  t_entry i_upper,
    output t_entry o_entry,
    output t_wave  o_wave
);

    t_entry r_entry;
    t_entry n_entry;
    t_wave  r_wave;
    t_wave  n_wave;
    t_entry w_fresh;
    logic   w_take_shift;

    assign w_fresh = '{valid: 1'b1, col: i_wave.col, slot: i_wave.slot};

    always_comb begin
        n_entry      = r_entry;
        n_wave       = i_wave;
        n_wave.valid = 1'b0;
        w_take_shift = 1'b0;
        if (i_wave.valid) begin
            case (i_wave.mode)
                WM_FIND_COL: begin
                    if (r_entry.valid && (r_entry.col == i_wave.col)) begin
                        w_take_shift = 1'b1;
                    end else begin
                        n_wave.valid = 1'b1;
                    end
                end
                WM_FIND_FREE: begin
                    if (!r_entry.valid) begin
                        n_entry = w_fresh;
                    end else begin
                        n_wave.valid = 1'b1;
                    end
                end
                WM_SHIFT: begin
                    w_take_shift = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // pull the newer neighbor down; the tail takes the requested column
        if (w_take_shift) begin
            if (i_upper.valid) begin
                n_entry      = i_upper;
                n_wave.valid = 1'b1;
                n_wave.mode  = WM_SHIFT;
            end else begin
                n_entry = w_fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_wave  <= '0;
        end else begin
            r_entry <= n_entry;
            r_wave  <= n_wave;
        end
    end

    assign o_entry = r_entry;
    assign o_wave  = r_wave;

endmodule

### rtl/core/lru_column_cache_unit.sv
// LRU column cache directory: one result word per request word, taken through
// accept, decide and finish; no new request word is taken before the last
// has left finish. The directory memory is single-port with a registered read;
// a result word held at the output stalls the following request in finish.
// Order updates ripple through the cell row one cell per cycle behind it.
// After reset all NCELL directory entries (at most 1024) are cleared
// before the first request word is taken; config writes are taken at once.
module lru_column_cache_unit
    import lcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [COL_W-1:0]     i_column_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_evicted_valid,
    output logic [COL_W-1:0]     o_evicted_column,
    output logic                 o_out_of_range
);

    localparam int NCELL = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
    localparam int AW    = $clog2(NCELL);
    localparam logic [CNT_W-1:0] NCELL_CNT = CNT_W'(NCELL);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(NCELL - 1);
    localparam t_entry           ENTRY_NONE = '0;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [CFG_W-1:0]  r_active;
    logic [CFG_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_used;

    // directory: resident flag and slot per column
    logic [SLOT_W:0]   r_dir [NCELL];
    logic [SLOT_W:0]   r_dir_rd;

    logic [COL_W-1:0]  r_col;
    logic              r_oor;
    logic              r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic              r_ev_valid;
    logic [COL_W-1:0]  r_ev_col;

    logic              r_out_valid;
    logic              r_o_hit;
    logic [SLOT_W-1:0] r_o_slot;
    logic              r_o_ev_valid;
    logic [COL_W-1:0]  r_o_ev_col;
    logic              r_o_oor;

    t_wave             r_launch;
    t_wave             n_launch;

    t_entry            w_entry [NCELL];
    t_wave             w_wave  [NCELL+1];

    logic              w_accept;
    logic              w_in_oor;
    logic              w_rd_hit;
    logic [CFG_W-1:0]  w_cap;
    logic              w_full;
    logic              w_evict;
    logic [SLOT_W-1:0] w_slot;
    logic              w_load;
    logic              w_dir_we;
    logic [AW-1:0]     w_dir_addr;
    logic [SLOT_W:0]   w_dir_wdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_in_oor    = ({1'b0, i_column_index} >= r_active)
                      || (32'(i_column_index) >= NCELL);

    // decide: a capacity below two acts as two, the row bounds it from above
    assign w_rd_hit = r_dir_rd[SLOT_W];
    assign w_cap    = (r_capacity < MIN_CAPACITY) ? MIN_CAPACITY : r_capacity;
    assign w_full   = (r_used >= w_cap) || (r_used >= NCELL_CNT);
    assign w_evict  = !w_rd_hit && w_full && w_entry[0].valid;
    assign w_slot   = w_rd_hit ? r_dir_rd[SLOT_W-1:0]
                    : w_evict  ? w_entry[0].slot
                    : r_used[SLOT_W-1:0];

    assign w_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_launch       = r_launch;
        n_launch.valid = 1'b0;
        if ((r_state == S_DECIDE) && !r_oor) begin
            n_launch.valid = 1'b1;
            n_launch.col   = r_col;
            n_launch.slot  = w_slot;
            if (w_rd_hit) begin
                n_launch.mode = WM_FIND_COL;
            end else if (w_evict) begin
                n_launch.mode = WM_SHIFT;
            end else begin
                n_launch.mode = WM_FIND_FREE;
            end
        end
    end

    always_comb begin
        w_dir_we    = 1'b0;
        w_dir_addr  = AW'(r_col);
        w_dir_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_dir_we   = 1'b1;
                w_dir_addr = r_clr_addr;
            end
            S_DECIDE: begin
                // drop the victim from the directory
                w_dir_we   = !r_oor && w_evict;
                w_dir_addr = AW'(w_entry[0].col);
            end
            S_FINISH: begin
                w_dir_we    = !r_oor && !r_hit;
                w_dir_wdata = {1'b1, r_slot};
            end
            S_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_dir_we) begin
            r_dir[w_dir_addr] <= w_dir_wdata;
        end
        if (w_accept) begin
            r_dir_rd <= r_dir[AW'(i_column_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_active    <= CFG_W'(1024);
            r_capacity  <= MIN_CAPACITY;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_launch    <= '0;
        end else begin
            r_launch <= n_launch;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ACTIVE) begin
                    r_active <= i_cfg_data;
                end else if (i_cfg_index == CFG_CAPACITY) begin
                    r_capacity <= i_cfg_data;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_oor && !w_rd_hit && !w_evict && (r_used < NCELL_CNT)) begin
                        r_used <= r_used + CNT_W'(1);
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col <= i_column_index;
            r_oor <= w_in_oor;
        end
        if (r_state == S_DECIDE) begin
            r_hit      <= !r_oor && w_rd_hit;
            r_slot     <= r_oor ? '0 : w_slot;
            r_ev_valid <= !r_oor && w_evict;
            r_ev_col   <= (!r_oor && w_evict) ? w_entry[0].col : '0;
        end
        if (w_load) begin
            r_o_hit      <= r_hit;
            r_o_slot     <= r_slot;
            r_o_ev_valid <= r_ev_valid;
            r_o_ev_col   <= r_ev_col;
            r_o_oor      <= r_oor;
        end
    end

    assign w_wave[0] = r_launch;

    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        if (gi < NCELL - 1) begin : g_mid
            lcc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wave  (w_wave[gi]),
                .i_upper (w_entry[gi+1]),
                .o_entry (w_entry[gi]),
                .o_wave  (w_wave[gi+1])
            );
        end else begin : g_last
            lcc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_wave  (w_wave[gi]),
                .i_upper (ENTRY_NONE),
                .o_entry (w_entry[gi]),
                .o_wave  (w_wave[gi+1])
            );
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_o_hit;
    assign o_slot           = r_o_slot;
    assign o_evicted_valid  = r_o_ev_valid;
    assign o_evicted_column = r_o_ev_col;
    assign o_out_of_range   = r_o_oor;

endmodule
